### design/bpc_pkg.sv
// shared types and constants for the button press classifier
package bpc_pkg;

    localparam int TIME_W   = 32;
    localparam int CFG_W    = 16;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_LONG_PRESS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_OFFLINE_GUARD = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOGGLE_GUARD  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_CLICK     = 3'd3;

    localparam logic [CFG_W-1:0] LONG_PRESS_RST    = 16'd3000;
    localparam logic [CFG_W-1:0] OFFLINE_GUARD_RST = 16'd1500;
    localparam logic [CFG_W-1:0] TOGGLE_GUARD_RST  = 16'd1000;
    localparam logic [CFG_W-1:0] MIN_CLICK_RST     = 16'd50;

    typedef struct packed {
        logic [31:0] now_ms;
        logic        key_down;
        logic        in_provisioning;
        logic        prov_busy;
        logic        button_locked;
        logic        login_ok;
        logic        session_active;
        logic        local_host;
        logic        shared_active;
    } bpc_in_t;

    typedef struct packed {
        logic request_offline;
        logic toggle_team;
        logic enter_config;
        logic offline_exit;
    } bpc_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] long_hold_ms;
        logic [CFG_W-1:0] offline_guard_ms;
        logic [CFG_W-1:0] toggle_guard_ms;
        logic [CFG_W-1:0] min_click_ms;
    } bpc_cfg_t;

    typedef struct packed {
        logic              held;
        logic              consumed;
        logic [TIME_W-1:0] press_time;
        logic [TIME_W-1:0] guard_until;
        logic [TIME_W-1:0] last_toggle;
    } bpc_state_t;

endpackage

### design/bpc_step.sv
// next-state and action pulses for one key sample
module bpc_step (
    input  bpc_pkg::bpc_in_t    item,
    input  bpc_pkg::bpc_cfg_t   cfg,
    input  bpc_pkg::bpc_state_t cur,
    output bpc_pkg::bpc_state_t nxt,
    output bpc_pkg::bpc_out_t   act
);
    import bpc_pkg::*;

    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] guard_diff;
    logic [TIME_W-1:0] hold_time;
    logic [TIME_W-1:0] since_toggle;
    logic [TIME_W-1:0] guard_end;
    logic              press_edge;
    logic              guard_on;
    logic              release_click;
    logic              toggle_blocked;

    assign now          = item.now_ms[TIME_W-1:0];
    assign guard_diff   = cur.guard_until - now;
    assign hold_time    = now - cur.press_time;
    assign since_toggle = now - cur.last_toggle;
    assign guard_end    = now + TIME_W'(cfg.offline_guard_ms);
    assign press_edge   = item.key_down && !cur.held;
    assign guard_on     = (cur.guard_until != '0) && (guard_diff != '0)
                          && !guard_diff[TIME_W-1];
    assign release_click = !item.key_down && cur.held && !cur.consumed
                           && (hold_time >= TIME_W'(cfg.min_click_ms));
    assign toggle_blocked = (cur.last_toggle != '0)
                            && (since_toggle < TIME_W'(cfg.toggle_guard_ms));

    always_comb
    begin
        nxt = cur;
        act = '0;
        if (press_edge)
        begin
            nxt.held       = 1'b1;
            nxt.consumed   = 1'b0;
            nxt.press_time = now;
            if (guard_on)
            begin
                nxt.consumed = 1'b1;
            end
            else if (item.in_provisioning)
            begin
                act.request_offline = 1'b1;
                nxt.guard_until     = guard_end;
                nxt.consumed        = 1'b1;
            end
        end
        if (item.key_down)
        begin
            // long press, measured from the press time after the edge update
            if (!nxt.consumed && ((now - nxt.press_time) >= TIME_W'(cfg.long_hold_ms)))
            begin
                nxt.consumed = 1'b1;
                if (item.login_ok)
                begin
                    act.enter_config = 1'b1;
                end
                else if (item.session_active || item.local_host || item.shared_active)
                begin
                    act.request_offline = 1'b1;
                    act.offline_exit    = 1'b1;
                    nxt.guard_until     = guard_end;
                end
                else
                begin
                    act.enter_config = 1'b1;
                end
            end
        end
        else
        begin
            if (release_click)
            begin
                if (item.in_provisioning)
                begin
                    act.request_offline = 1'b1;
                    nxt.guard_until     = guard_end;
                end
                else if (!item.prov_busy && !item.button_locked && !toggle_blocked)
                begin
                    act.toggle_team = 1'b1;
                    nxt.last_toggle = now;
                end
            end
            nxt.held     = 1'b0;
            nxt.consumed = 1'b0;
        end
    end

endmodule

### design/button_press_classifier_core.sv
// top level of the button press classifier: beat registers, config and state
//
//  channel | direction | handshake             | beat
//  in      | input     | in_valid / in_ready   | in_data   (bpc_in_t)
//  out     | output    | out_valid / out_ready | out_data  (bpc_out_t)
//  cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
//  one beat per cycle sustained while out_ready is high; an accepted beat passes the input
//  register, then step logic into the result register, before out_valid rises
//  reset clears the valid flags and press state and loads the register defaults; cfg_ready is always high
//  a stalled result holds the input register, which still takes one more beat
module button_press_classifier_core (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  bpc_pkg::bpc_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output bpc_pkg::bpc_out_t                 out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bpc_pkg::CFG_W-1:0]         cfg_data
);
    import bpc_pkg::*;

    bpc_in_t    item_reg;
    logic       item_valid_reg;
    bpc_out_t   res_reg;
    logic       res_valid_reg;
    bpc_cfg_t   cfg_reg;
    bpc_cfg_t   cfg_next;
    bpc_state_t st_reg;
    bpc_state_t st_next;
    bpc_out_t   act;
    logic       advance;

    assign advance   = item_valid_reg && (!res_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign out_valid = res_valid_reg;
    assign out_data  = res_reg;
    assign cfg_ready = 1'b1;

    bpc_step u_step (
        .item (item_reg),
        .cfg  (cfg_reg),
        .cur  (st_reg),
        .nxt  (st_next),
        .act  (act)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_LONG_PRESS:    cfg_next.long_hold_ms     = cfg_data;
                CFG_OFFLINE_GUARD: cfg_next.offline_guard_ms = cfg_data;
                CFG_TOGGLE_GUARD:  cfg_next.toggle_guard_ms  = cfg_data;
                CFG_MIN_CLICK:     cfg_next.min_click_ms     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg           <= 1'b0;
            res_valid_reg            <= 1'b0;
            st_reg                   <= '0;
            cfg_reg.long_hold_ms     <= LONG_PRESS_RST;
            cfg_reg.offline_guard_ms <= OFFLINE_GUARD_RST;
            cfg_reg.toggle_guard_ms  <= TOGGLE_GUARD_RST;
            cfg_reg.min_click_ms     <= MIN_CLICK_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
            if (in_ready)
            begin
                item_valid_reg <= in_valid;
            end
            if (advance)
            begin
                st_reg        <= st_next;
                res_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                res_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= in_data;
        end
        if (advance)
        begin
            res_reg <= act;
        end
    end

    a_exit_with_offline: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.offline_exit |-> out_data.request_offline)
        else $error("offline exit without offline request");

    a_toggle_alone: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.toggle_team |->
            !out_data.request_offline && !out_data.enter_config)
        else $error("team toggle together with another action");

    a_config_not_exit: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.enter_config |-> !out_data.offline_exit)
        else $error("config entry together with offline exit");

    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid_reg && out_valid && !out_ready |-> !in_ready)
        else $error("input taken while both stages are held");

    a_held_after_press: assert property (@(posedge clk) disable iff (!rst_n)
        advance && item_reg.key_down |=> st_reg.held)
        else $error("key sample down but press not held");

endmodule
